// ===== rtl/sitda_pkg.sv =====
package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  // Binary bits folded into the BCD register per dabble step.
  localparam int DABBLE_BITS = 4;
  localparam int DABBLE_STEPS = VALUE_W / DABBLE_BITS;
  localparam int DCNT_W = $clog2(DABBLE_STEPS);
  localparam int IDX_W  = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_DABBLE = 3'd1;
  localparam step_t STEP_SKIP   = 3'd2;
  localparam step_t STEP_SIGN   = 3'd3;
  localparam step_t STEP_DIGIT  = 3'd4;
  localparam step_t STEP_RETURN = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_DIGIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_MORE,
    C_LEADZ,
    C_NOTLAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic more;
    logic leadz;
    logic notlast;
  } status_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Channel   Ports                          Handshake
// input     value                          accepted when start && !busy
// result    char_code, last_char           one cycle per character, char_valid high
//
// Between acceptance and the next acceptance a word runs through 8 double-dabble
// steps of 4 bits each, one skip step per leading zero plus one, a sign step,
// one step per digit and a return step, all driven by the microcode sequencer.
// Characters leave one per cycle, each in the cycle after its step, most significant first.
// Reset (rst, synchronous) returns the sequencer to idle and clears char_valid.
// The receiver cannot stall; each character is shown for exactly one cycle.
module signed_int_to_decimal_ascii_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  output logic [7:0]                           char_code,
  output logic                                 last_char,
  output logic                                 char_valid
);

  sitda_pkg::ctrl_t   ctrl;
  sitda_pkg::status_t status;

  sitda_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  sitda_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value      (value),
    .ctrl       (ctrl),
    .status     (status),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_valid (char_valid)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last_char) |=> !char_valid)
    else $error("character emitted right after the last one");

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> $past(busy))
    else $error("character emitted while the sequencer was idle");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && (char_code == sitda_pkg::CHAR_MINUS)) |-> !last_char)
    else $error("minus sign flagged as last character");

endmodule

// ===== rtl/sitda_sequencer.sv =====
module sitda_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sitda_pkg::status_t  status,
  output sitda_pkg::ctrl_t    ctrl,
  output logic                busy
);

  sitda_pkg::step_t pc;
  sitda_pkg::step_t pc_next;
  logic             jump;

  // Microprogram: one control word per step.
  function automatic sitda_pkg::ctrl_t rom(input sitda_pkg::step_t addr);
    sitda_pkg::ctrl_t w;
    w = '{op: sitda_pkg::OP_NOP, cond: sitda_pkg::C_ALWAYS, target: sitda_pkg::STEP_IDLE};
    case (addr)
      sitda_pkg::STEP_IDLE:   w = '{op: sitda_pkg::OP_LOAD, cond: sitda_pkg::C_NOSTART,
                                    target: sitda_pkg::STEP_IDLE};
      sitda_pkg::STEP_DABBLE: w = '{op: sitda_pkg::OP_DABBLE, cond: sitda_pkg::C_MORE,
                                    target: sitda_pkg::STEP_DABBLE};
      sitda_pkg::STEP_SKIP:   w = '{op: sitda_pkg::OP_SKIP, cond: sitda_pkg::C_LEADZ,
                                    target: sitda_pkg::STEP_SKIP};
      sitda_pkg::STEP_SIGN:   w = '{op: sitda_pkg::OP_SIGN, cond: sitda_pkg::C_NEVER,
                                    target: sitda_pkg::STEP_IDLE};
      sitda_pkg::STEP_DIGIT:  w = '{op: sitda_pkg::OP_DIGIT, cond: sitda_pkg::C_NOTLAST,
                                    target: sitda_pkg::STEP_DIGIT};
      sitda_pkg::STEP_RETURN: w = '{op: sitda_pkg::OP_NOP, cond: sitda_pkg::C_ALWAYS,
                                    target: sitda_pkg::STEP_IDLE};
      default:                w = '{op: sitda_pkg::OP_NOP, cond: sitda_pkg::C_ALWAYS,
                                    target: sitda_pkg::STEP_IDLE};
    endcase
    return w;
  endfunction

  assign ctrl = rom(pc);
  assign busy = (pc != sitda_pkg::STEP_IDLE);

  always_comb begin
    case (ctrl.cond)
      sitda_pkg::C_NEVER:   jump = 1'b0;
      sitda_pkg::C_ALWAYS:  jump = 1'b1;
      sitda_pkg::C_NOSTART: jump = !start;
      sitda_pkg::C_MORE:    jump = status.more;
      sitda_pkg::C_LEADZ:   jump = status.leadz;
      sitda_pkg::C_NOTLAST: jump = status.notlast;
      default:              jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : pc + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sitda_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/sitda_datapath.sv =====
module sitda_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  input  sitda_pkg::ctrl_t                    ctrl,
  output sitda_pkg::status_t                  status,
  output logic [7:0]                          char_code,
  output logic                                last_char,
  output logic                                char_valid
);

  logic [sitda_pkg::VALUE_W-1:0] mag;
  logic [sitda_pkg::BCD_W-1:0]   bcd;
  logic                          neg;
  logic [sitda_pkg::DCNT_W-1:0]  dcnt;
  logic [sitda_pkg::IDX_W-1:0]   idx;

  logic [sitda_pkg::VALUE_W-1:0] mag_next;
  logic [sitda_pkg::BCD_W-1:0]   bcd_next;
  logic [3:0]                    top_digit;
  logic                          idx_last;

  // Shift-and-add-3 conversion, several binary bits per step.
  always_comb begin
    logic [sitda_pkg::VALUE_W-1:0] m;
    logic [sitda_pkg::BCD_W-1:0]   b;
    m = mag;
    b = bcd;
    for (int s = 0; s < sitda_pkg::DABBLE_BITS; s++) begin
      for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[sitda_pkg::BCD_W-2:0], m[sitda_pkg::VALUE_W-1]};
      m = {m[sitda_pkg::VALUE_W-2:0], 1'b0};
    end
    mag_next = m;
    bcd_next = b;
  end

  assign top_digit = bcd[sitda_pkg::BCD_W-1 -: 4];
  assign idx_last  = (idx == sitda_pkg::IDX_W'(sitda_pkg::NUM_DIGITS - 1));

  assign status.more    = (dcnt != sitda_pkg::DCNT_W'(sitda_pkg::DABBLE_STEPS - 1));
  assign status.leadz   = (top_digit == 4'd0) && !idx_last;
  assign status.notlast = !idx_last;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      sitda_pkg::OP_LOAD: begin
        if (start) begin
          neg  <= value[sitda_pkg::VALUE_W-1];
          // The most negative value wraps to its unsigned magnitude.
          mag  <= value[sitda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
          bcd  <= '0;
          dcnt <= '0;
          idx  <= '0;
        end
      end
      sitda_pkg::OP_DABBLE: begin
        mag  <= mag_next;
        bcd  <= bcd_next;
        dcnt <= dcnt + 1'b1;
      end
      sitda_pkg::OP_SKIP: begin
        if (status.leadz) begin
          bcd <= {bcd[sitda_pkg::BCD_W-5:0], 4'd0};
          idx <= idx + 1'b1;
        end
      end
      sitda_pkg::OP_SIGN: begin
        char_code <= sitda_pkg::CHAR_MINUS;
        last_char <= 1'b0;
      end
      sitda_pkg::OP_DIGIT: begin
        char_code <= sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
        last_char <= idx_last;
        bcd       <= {bcd[sitda_pkg::BCD_W-5:0], 4'd0};
        idx       <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= (ctrl.op == sitda_pkg::OP_DIGIT) ||
                    ((ctrl.op == sitda_pkg::OP_SIGN) && neg);
    end
  end

endmodule

// ===== bench/tb_signed_int_to_decimal_ascii_top.sv =====
module tb_signed_int_to_decimal_ascii_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         VALUE_W    = sitda_pkg::VALUE_W;
  localparam int         NUM_DIGITS = sitda_pkg::NUM_DIGITS;
  localparam logic [7:0] CHAR_ZERO  = sitda_pkg::CHAR_ZERO;
  localparam logic [7:0] CHAR_MINUS = sitda_pkg::CHAR_MINUS;

  localparam int LIMIT_CYCLES   = 100000;
  localparam int DRAIN_CYCLES   = 30;
  localparam longint MAG_LIMIT  = 64'sd2147483648;
  localparam logic [VALUE_W-1:0] RADIX = 10;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] value;
  logic [7:0]                char_code;
  logic                      last_char;
  logic                      char_valid;

  ascii_char_t expected_chars[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 25;

  signed_int_to_decimal_ascii_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_valid (char_valid)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Expected text of one word: sign first, then digits most significant first.
  function automatic void push_decimal_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [7:0]         digits [NUM_DIGITS];
    int                 ndig;
    mag = v;
    if (v[VALUE_W-1]) mag = ~mag + 1'b1;
    ndig = 0;
    do begin
      digits[ndig] = CHAR_ZERO + 8'(mag % RADIX);
      mag = mag / RADIX;
      ndig++;
    end while (mag != 0);
    if (v[VALUE_W-1]) expected_chars.push_back(ascii_char_t'{CHAR_MINUS, 1'b0});
    for (int k = ndig - 1; k >= 0; k--) begin
      expected_chars.push_back(ascii_char_t'{digits[k], k == 0});
    end
  endfunction

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    repeat (n) p *= 10;
    return p;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_ndigit(input int ndig, input bit neg);
    longint lo, hi, mag;
    lo = (ndig == 1) ? 0 : pow10(ndig - 1);
    hi = pow10(ndig) - 1;
    if (hi > MAG_LIMIT) hi = MAG_LIMIT;
    mag = $urandom_range(32'(hi), 32'(lo));
    // Only the negative side can reach a magnitude of two to the 31st.
    if (mag == MAG_LIMIT) neg = 1'b1;
    return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    longint mag;
    case ($urandom_range(3, 0))
      0: begin
        return $urandom;
      end
      1, 2: begin
        return random_ndigit($urandom_range(NUM_DIGITS, 1), 1'($urandom_range(1, 0)));
      end
      default: begin
        // Neighbors of powers of ten change the digit count.
        mag = pow10($urandom_range(NUM_DIGITS - 1, 0)) + $urandom_range(2, 0) - 1;
        return $urandom_range(1, 0) ? VALUE_W'(-mag) : VALUE_W'(mag);
      end
    endcase
  endfunction

  // Start drops on randomly drawn idle cycles; otherwise the word waits on the port.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    logic accepted;
    accepted = 1'b0;
    while (!accepted) begin
      if ($urandom_range(99, 0) < idle_pct) begin
        start <= 1'b0;
        value <= $urandom;
      end else begin
        start <= 1'b1;
        value <= v;
      end
      @(posedge clk);
      accepted = start && !busy;
    end
    push_decimal_text(v);
  endtask

  task automatic test_extremes();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(-9);
    send_value(10);
    send_value(100);
    send_value(999999999);
    send_value(1000000000);
    send_value(-1000000000);
    send_value(32'sh7FFFFFFF);
    send_value(32'sh80000000);
    send_value(32'sh80000001);
  endtask

  task automatic test_digit_counts();
    for (int n = 1; n <= NUM_DIGITS; n++) begin
      send_value(random_ndigit(n, n[0]));
    end
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back(input int count);
    idle_pct = 0;
    repeat (count) send_value(random_value());
    idle_pct = 25;
  endtask

  always @(posedge clk) begin : check_chars
    ascii_char_t want;
    if (!rst && char_valid) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h", char_code));
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code)
          report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h", char_code, want.code));
        if (last_char !== want.last)
          report_mismatch($sformatf("last_char %b, wanted %b", last_char, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[signed_int_to_decimal_ascii_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_digit_counts();
    test_random_values(107);
    test_back_to_back(50);
    start <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[signed_int_to_decimal_ascii_top] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii_top] ERROR");
    end
    $finish;
  end

endmodule
